@@ hdl/rrc_pkg.sv @@
// Shared types and constants for the rotation-count block.
// No dependencies; imported by the interfaces, rrc_search, the top module and the bench.
package rrc_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned ROT_W   = 10;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD_LO,
		ST_RD_HI,
		ST_RD_MD,
		ST_EVAL,
		ST_DONE
	} state_t;

endpackage

@@ hdl/rrc_if.sv @@
// Valid/ready channel interfaces for element input and result output.
// Depends on rrc_pkg for the payload widths.
interface rrc_elem_if
	import rrc_pkg::*;
	;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface rrc_res_if
	import rrc_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [ROT_W-1:0] rotations;

	modport source (output valid, output rotations, input ready);
	modport sink (input valid, input rotations, output ready);
endinterface

@@ hdl/rrc_store.sv @@
// Element store: one write port, one read port, registered read data.
// No package dependencies.
module rrc_store #(
	parameter int unsigned DEPTH  = 1024,
	parameter int unsigned ADDR_W = 10,
	parameter int unsigned DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/rrc_search.sv @@
// Load counter, search sequencer and result register for the rotation count.
// Depends on rrc_pkg and the channel interfaces; drives the element store.
module rrc_search
	import rrc_pkg::*;
#(
	parameter int unsigned MAX_ELEMENTS = 1024,
	parameter int unsigned VALUE_BITS   = 32,
	parameter int unsigned IDX_W        = 10,
	parameter int unsigned CNT_W        = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rrc_elem_if.sink              elem,
	rrc_res_if.source             res,
	output logic                  mem_we,
	output logic [IDX_W-1:0]      mem_waddr,
	output logic [VALUE_BITS-1:0] mem_wdata,
	output logic [IDX_W-1:0]      mem_raddr,
	input  logic [VALUE_BITS-1:0] mem_rdata
);

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ELEMENTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

	state_t state_q, state_nx;

	logic [CNT_W-1:0]             cnt_q;
	logic [CNT_W-1:0]             low_q;
	logic [IDX_W-1:0]             high_q;
	logic [IDX_W-1:0]             mid_q;
	logic signed [VALUE_BITS-1:0] lo_q, hi_q, best_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic                         res_valid_q;
	logic [ROT_W-1:0]             rot_q;

	logic                         full;
	logic                         accept;
	logic [CNT_W:0]               span_sum;
	logic signed [VALUE_BITS-1:0] md;
	logic                         ev_done;
	logic                         ev_upd;
	logic signed [VALUE_BITS-1:0] ev_val;
	logic [IDX_W-1:0]             ev_idx;
	logic [CNT_W-1:0]             low_nx;
	logic [IDX_W-1:0]             high_nx;
	logic                         res_free;

	generate
		if (VALUE_BITS <= VALUE_W) begin : g_narrow
			assign mem_wdata = elem.value[VALUE_BITS-1:0];
		end else begin : g_wide
			assign mem_wdata = {{(VALUE_BITS - VALUE_W){1'b0}}, elem.value};
		end
	endgenerate

	assign full      = (cnt_q == FULL_CNT);
	assign accept    = elem.valid && elem.ready;
	assign mem_we    = accept && !full;
	assign mem_waddr = cnt_q[IDX_W-1:0];
	assign span_sum  = (CNT_W + 1)'(low_q) + (CNT_W + 1)'(high_q);
	assign md        = mem_rdata;
	assign res_free  = !res_valid_q || res.ready;

	assign res.valid     = res_valid_q;
	assign res.rotations = rot_q;

	// one search pass: decide on lo/hi/mid and shrink the span
	always_comb begin
		ev_done = 1'b0;
		ev_upd  = 1'b0;
		ev_val  = lo_q;
		ev_idx  = low_q[IDX_W-1:0];
		low_nx  = low_q;
		high_nx = high_q;
		if (lo_q <= hi_q) begin
			ev_upd  = (lo_q < best_q);
			ev_done = 1'b1;
		end else if (lo_q <= md) begin
			ev_upd  = (lo_q < best_q);
			low_nx  = CNT_W'(mid_q) + CNT_W'(1);
			ev_done = (low_nx > CNT_W'(high_q));
		end else begin
			ev_upd  = (md < best_q);
			ev_val  = md;
			ev_idx  = mid_q;
			ev_done = (low_q == CNT_W'(mid_q));
			if (!ev_done) begin
				high_nx = mid_q - IDX_W'(1);
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD:  if (accept && elem.last) state_nx = ST_RD_LO;
			ST_RD_LO: state_nx = ST_RD_HI;
			ST_RD_HI: state_nx = ST_RD_MD;
			ST_RD_MD: state_nx = ST_EVAL;
			ST_EVAL:  state_nx = ev_done ? ST_DONE : ST_RD_LO;
			ST_DONE:  if (res_free) state_nx = ST_LOAD;
			default:  state_nx = ST_LOAD;
		endcase
	end

	always_comb begin
		elem.ready = 1'b0;
		mem_raddr  = low_q[IDX_W-1:0];
		unique case (state_q)
			ST_LOAD:  elem.ready = 1'b1;
			ST_RD_LO: mem_raddr  = low_q[IDX_W-1:0];
			ST_RD_HI: mem_raddr  = high_q;
			ST_RD_MD: mem_raddr  = mid_q;
			ST_EVAL:  mem_raddr  = low_q[IDX_W-1:0];
			ST_DONE:  mem_raddr  = low_q[IDX_W-1:0];
			default:  elem.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			low_q       <= '0;
			high_q      <= '0;
			best_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_LOAD && accept) begin
				if (elem.last) begin
					cnt_q      <= '0;
					low_q      <= '0;
					high_q     <= full ? LAST_IDX : cnt_q[IDX_W-1:0];
					best_idx_q <= '0;
				end else if (!full) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (state_q == ST_EVAL) begin
				low_q  <= low_nx;
				high_q <= high_nx;
				if (ev_upd) begin
					best_idx_q <= ev_idx;
				end
			end
			if (state_q == ST_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && accept && elem.last) begin
			best_q <= {1'b0, {(VALUE_BITS - 1){1'b1}}};
		end
		if (state_q == ST_RD_LO) begin
			mid_q <= span_sum[IDX_W:1];
		end
		if (state_q == ST_RD_HI) begin
			lo_q <= mem_rdata;
		end
		if (state_q == ST_RD_MD) begin
			hi_q <= mem_rdata;
		end
		if (state_q == ST_EVAL && ev_upd) begin
			best_q <= ev_val;
		end
		if (state_q == ST_DONE && res_free) begin
			rot_q <= ROT_W'(best_idx_q);
		end
	end

endmodule

@@ hdl/rotated_array_rotation_count.sv @@
// Rotation count of a rotated ascending array: elements load one beat per cycle while
// in the load state. After the last beat, each of at most log2(n)+1 search passes reads
// low, high and mid in turn through the one store read port, then evaluates them.
// New elements are taken again once the result sits in the output register.
// Reset clears control state only; store contents stay undefined until written.
// Depends on rrc_pkg, rrc_if, rrc_store and rrc_search.
module rotated_array_rotation_count
	import rrc_pkg::*;
#(
	parameter int unsigned MAX_ELEMENTS = 1024,
	parameter int unsigned VALUE_BITS   = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	rrc_elem_if.sink  elem,
	rrc_res_if.source res
);

	localparam int unsigned IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic [IDX_W-1:0]      mem_raddr;
	logic [VALUE_BITS-1:0] mem_rdata;

	rrc_store #(
		.DEPTH  (MAX_ELEMENTS),
		.ADDR_W (IDX_W),
		.DATA_W (VALUE_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rrc_search #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_BITS   (VALUE_BITS),
		.IDX_W        (IDX_W),
		.CNT_W        (CNT_W)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.elem      (elem),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

@@ sim/rotated_array_rotation_count_tb.sv @@
// Self-checking bench for rotated_array_rotation_count: streams rotated arrays, checks counts.
// A directed table runs first, then a store overflow, a receiver hold-off and random arrays.
// Depends on rrc_pkg, rrc_if and the block's RTL.
module rotated_array_rotation_count_tb;
	import rrc_pkg::*;

	localparam int STORE_DEPTH   = 1024;
	localparam int RANDOM_BEATS  = 650;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int SEARCH_TAIL   = 64;
	localparam int IDLE_PCT      = 37;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum int {ARR_ROTATED, ARR_RANDOM, ARR_REPEATS} array_kind_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		bit                        last;
		bit                        typed;
		logic [ROT_W-1:0]          rotations;
	} elem_row_t;

	logic clk;
	logic arst_n;

	rrc_elem_if elem_ch ();
	rrc_res_if  res_ch ();

	rotated_array_rotation_count u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem_ch),
		.res    (res_ch)
	);

	logic signed [VALUE_W-1:0] elem_image [STORE_DEPTH];
	int                        fill_cnt = 0;
	logic [ROT_W-1:0]          rotation_expect_q [$];

	int idle_pct     = IDLE_PCT;
	int hold_req     = 0;
	int errors       = 0;
	int beats        = 0;
	int arrays       = 0;
	int counts_ok    = 0;
	int longest      = 0;

	elem_row_t dir_rows [25] = '{
		'{32'sd0,    1'b1, 1'b1, 10'd0},
		'{VAL_MIN,   1'b1, 1'b1, 10'd0},
		'{VAL_MAX,   1'b1, 1'b1, 10'd0},
		'{VAL_MAX,   1'b0, 1'b0, 10'd0},
		'{VAL_MAX,   1'b1, 1'b1, 10'd0},
		'{VAL_MAX,   1'b0, 1'b0, 10'd0},
		'{VAL_MIN,   1'b1, 1'b1, 10'd1},
		'{VAL_MIN,   1'b0, 1'b0, 10'd0},
		'{VAL_MAX,   1'b1, 1'b1, 10'd0},
		'{32'sd30,   1'b0, 1'b0, 10'd0},
		'{32'sd40,   1'b0, 1'b0, 10'd0},
		'{-32'sd5,   1'b0, 1'b0, 10'd0},
		'{32'sd10,   1'b0, 1'b0, 10'd0},
		'{32'sd20,   1'b1, 1'b1, 10'd2},
		'{32'sd7,    1'b0, 1'b0, 10'd0},
		'{32'sd7,    1'b0, 1'b0, 10'd0},
		'{32'sd3,    1'b0, 1'b0, 10'd0},
		'{32'sd7,    1'b1, 1'b0, 10'd0},
		'{-32'sd100, 1'b0, 1'b0, 10'd0},
		'{-32'sd50,  1'b0, 1'b0, 10'd0},
		'{32'sd0,    1'b0, 1'b0, 10'd0},
		'{32'sd50,   1'b0, 1'b0, 10'd0},
		'{-32'sd200, 1'b1, 1'b1, 10'd4},
		'{32'sd5,    1'b0, 1'b0, 10'd0},
		'{32'sd9,    1'b1, 1'b0, 10'd0}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [ROT_W-1:0] find_min_index(input int n);
		int                        lo;
		int                        hi;
		int                        mid;
		int                        best_idx;
		logic signed [VALUE_W-1:0] a;
		logic signed [VALUE_W-1:0] b;
		logic signed [VALUE_W-1:0] m;
		logic signed [VALUE_W-1:0] best;
		lo = 0;
		hi = n - 1;
		best = VAL_MAX;
		best_idx = 0;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			a = elem_image[lo];
			b = elem_image[hi];
			m = elem_image[mid];
			if (a <= b) begin
				if (a < best) begin
					best = a;
					best_idx = lo;
				end
				break;
			end else if (a <= m) begin
				if (a < best) begin
					best = a;
					best_idx = lo;
				end
				lo = mid + 1;
			end else begin
				if (m < best) begin
					best = m;
					best_idx = mid;
				end
				if (mid == 0)
					break;
				hi = mid - 1;
			end
		end
		return best_idx[ROT_W-1:0];
	endfunction

	function automatic bit predict_rotation(input logic signed [VALUE_W-1:0] v, input bit l,
			output logic [ROT_W-1:0] rot);
		rot = '0;
		if (fill_cnt < STORE_DEPTH) begin
			elem_image[fill_cnt] = v;
			fill_cnt++;
		end
		if (!l)
			return 1'b0;
		rot = find_min_index(fill_cnt);
		fill_cnt = 0;
		return 1'b1;
	endfunction

	task automatic send_beat(input logic signed [VALUE_W-1:0] v, input bit l, input bit typed,
			input logic [ROT_W-1:0] typed_rot);
		logic [ROT_W-1:0] rot;
		while ($urandom_range(0, 99) < idle_pct) begin
			elem_ch.valid <= 1'b0;
			@(posedge clk);
		end
		elem_ch.valid <= 1'b1;
		elem_ch.value <= v;
		elem_ch.last  <= l;
		@(posedge clk);
		while (elem_ch.ready !== 1'b1)
			@(posedge clk);
		beats++;
		if (predict_rotation(v, l, rot)) begin
			arrays++;
			rotation_expect_q = {rotation_expect_q, (typed ? typed_rot : rot)};
		end
	endtask

	task automatic send_array(input int n, input array_kind_t kind);
		logic signed [VALUE_W-1:0] sorted_vals [$];
		longint                    base;
		longint                    span;
		longint                    step_max;
		longint                    cur;
		int                        shift;
		if (n > longest)
			longest = n;
		case (kind)
			ARR_ROTATED: begin
				base = longint'(signed'($urandom));
				if (base > longint'(VAL_MAX) - n)
					base = longint'(VAL_MIN);
				span = longint'(VAL_MAX) - base;
				step_max = span / n;
				if ($urandom_range(0, 3) == 0 && step_max > 3)
					step_max = 3;
				cur = base;
				for (int i = 0; i < n; i++) begin
					sorted_vals = {sorted_vals, cur[VALUE_W-1:0]};
					cur += 1 + (longint'($urandom) % step_max);
				end
				shift = $urandom_range(0, n - 1);
				for (int i = 0; i < n; i++)
					send_beat(sorted_vals[(i + shift) % n], i == n - 1, 1'b0, '0);
			end
			ARR_RANDOM: begin
				for (int i = 0; i < n; i++)
					send_beat(signed'($urandom), i == n - 1, 1'b0, '0);
			end
			default: begin
				for (int i = 0; i < n; i++)
					send_beat(int'($urandom_range(0, 6)) - 3, i == n - 1, 1'b0, '0);
			end
		endcase
	endtask

	task automatic drain();
		elem_ch.valid <= 1'b0;
		while (rotation_expect_q.size() != 0)
			@(posedge clk);
		repeat (SEARCH_TAIL) @(posedge clk);
	endtask

	initial begin
		int hold_seen;
		int hold_left;
		logic [ROT_W-1:0] want;
		hold_seen = 0;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				if (rotation_expect_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected rotation count %0d", $time, res_ch.rotations);
				end else begin
					want = rotation_expect_q.pop_front();
					if (res_ch.rotations !== want) begin
						errors++;
						$display("%0t: rotations expected %0d actual %0d", $time, want,
							res_ch.rotations);
					end else begin
						counts_ok++;
					end
				end
			end
			if (arst_n !== 1'b1) begin
				res_ch.ready <= 1'b0;
			end else if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((elem_ch.valid === 1'b1 && elem_ch.ready === 1'b1) ||
					(res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
				stall = 0;
			else
				stall++;
		end
		$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
		$display("rotated_array_rotation_count_tb NOT OK");
		$finish;
	end

	initial begin
		int pick;
		int n;
		int quiet_from;
		array_kind_t kind;
		arst_n = 1'b0;
		elem_ch.valid = 1'b0;
		elem_ch.value = '0;
		elem_ch.last  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed,
				dir_rows[i].rotations);
		drain();

		idle_pct = 0;
		send_array(STORE_DEPTH + 6, ARR_ROTATED);
		drain();

		hold_req++;
		repeat (6) send_array(3, ARR_ROTATED);
		drain();
		idle_pct = IDLE_PCT;

		quiet_from = beats + 200;
		n = beats + RANDOM_BEATS;
		while (beats < n) begin
			idle_pct = (beats >= quiet_from && beats < quiet_from + 150) ? 0 : IDLE_PCT;
			pick = $urandom_range(0, 99);
			kind = (pick < 80) ? ARR_ROTATED : (pick < 90) ? ARR_RANDOM : ARR_REPEATS;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				send_array($urandom_range(1, 8), kind);
			else if (pick < 88)
				send_array($urandom_range(9, 40), kind);
			else if (pick < 99)
				send_array($urandom_range(41, 150), kind);
			else
				send_array($urandom_range(600, STORE_DEPTH), kind);
		end
		idle_pct = IDLE_PCT;
		drain();

		$display("run: %0d arrays, %0d element beats, %0d rotation counts matched, longest %0d",
			arrays, beats, counts_ok, longest);
		$display("run: store overflow, receiver hold-off with input stall, repeats and noise");
		if (errors == 0)
			$display("rotated_array_rotation_count_tb OK");
		else
			$display("rotated_array_rotation_count_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
hdl/rrc_pkg.sv
hdl/rrc_if.sv
hdl/rrc_store.sv
hdl/rrc_search.sv
hdl/rotated_array_rotation_count.sv
sim/rotated_array_rotation_count_tb.sv
